FILE: rtl/bitmap_side_collision_probe_assert.svh
// Assertion macros shared by the side collision probe RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef BITMAP_SIDE_COLLISION_PROBE_ASSERT_SVH
`define BITMAP_SIDE_COLLISION_PROBE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSCP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bscp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bscp: next-cycle check failed");

`endif

FILE: rtl/bscp_pkg.sv
// Shared constants, types and helper functions of the side collision probe.
// Used by the channel interfaces, the zone decoder and the top level.
package bscp_pkg;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int NUM_SIDES = 4;
    localparam int unsigned SURFACE_DIM = 4096;

    localparam logic [COLOR_W-1:0] BLACK_LEVEL = 8'h00;

    // Side codes as they appear on the result channel.
    localparam logic [1:0] SIDE_TOP = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_RECT_LEFT = 3'd0;
    localparam logic [2:0] REG_RECT_TOP = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_REPORT_MODE = 3'd4;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t width;
        coord_t height;
    } rect_cfg_t;

    typedef struct packed {
        logic right;
        logic left;
        logic bottom;
        logic top;
    } zone_hit_t;

    // True when a candidate beats the kept hit of a side. The primary
    // coordinate prefers the larger value when big is set, else the smaller;
    // ties go to the smaller secondary coordinate.
    function automatic logic side_better(
        input logic   found,
        input coord_t cand_pri,
        input coord_t cand_sec,
        input coord_t best_pri,
        input coord_t best_sec,
        input logic   big
    );
        logic res;
        if (!found) begin
            res = 1'b1;
        end else if (cand_pri != best_pri) begin
            res = big ? (cand_pri > best_pri) : (cand_pri < best_pri);
        end else begin
            res = cand_sec < best_sec;
        end
        return res;
    endfunction

endpackage

FILE: rtl/bscp_pixel_if.sv
// Request channel that carries one surface pixel per request.
// Depends on bscp_pkg for the field types.
interface bscp_pixel_if;
    logic              valid;
    logic              ready;
    bscp_pkg::coord_t  pixel_x;
    bscp_pkg::coord_t  pixel_y;
    bscp_pkg::color_t  red;
    bscp_pkg::color_t  green;
    bscp_pkg::color_t  blue;
    logic              last_pixel;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, last_pixel,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, red, green, blue, last_pixel,
                  output ready);
endinterface

FILE: rtl/bscp_result_if.sv
// Request channel that carries one side report per request.
// Depends on bscp_pkg for the field types.
interface bscp_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        side;
    logic              found;
    bscp_pkg::coord_t  hit_x;
    bscp_pkg::coord_t  hit_y;
    logic              last;

    modport source (output valid, side, found, hit_x, hit_y, last, input ready);
    modport sink (input valid, side, found, hit_x, hit_y, last, output ready);
endinterface

FILE: rtl/bscp_zone.sv
// Zone decoder: tells which of the four probe zones a pixel hits.
// Depends on bscp_pkg for the rectangle and hit types.
module bscp_zone (
    input  bscp_pkg::rect_cfg_t rect,
    input  bscp_pkg::coord_t    px,
    input  bscp_pkg::coord_t    py,
    input  bscp_pkg::color_t    red,
    input  bscp_pkg::color_t    green,
    input  bscp_pkg::color_t    blue,
    output bscp_pkg::zone_hit_t hit
);

    localparam int EXT_W = bscp_pkg::COORD_W + 1;

    logic             black;
    logic             on_surface;
    logic [EXT_W-1:0] x, y, x0, y0, x_end, y_end, x_mid, y_mid;
    logic             in_cols, in_rows;

    always_comb
    begin
        black = (red == bscp_pkg::BLACK_LEVEL) && (green == bscp_pkg::BLACK_LEVEL)
                && (blue == bscp_pkg::BLACK_LEVEL);
        on_surface = (32'(px) < bscp_pkg::SURFACE_DIM) && (32'(py) < bscp_pkg::SURFACE_DIM);

        x = EXT_W'(px);
        y = EXT_W'(py);
        x0 = EXT_W'(rect.left);
        y0 = EXT_W'(rect.top);
        x_end = x0 + EXT_W'(rect.width);
        y_end = y0 + EXT_W'(rect.height);
        x_mid = x0 + EXT_W'(rect.width >> 1);
        y_mid = y0 + EXT_W'(rect.height >> 1);

        // x < x0 + w - 1 is written as x + 1 < x0 + w so nothing goes negative.
        in_cols = (x >= x0) && ((x + EXT_W'(1)) < x_end);
        in_rows = (y >= y0) && ((y + EXT_W'(1)) < y_end);

        hit.top = black && on_surface && in_cols && (y > y0) && (y <= y_mid);
        hit.bottom = black && on_surface && in_cols && (y >= y_mid) && (y < y_end);
        hit.left = black && on_surface && in_rows && (x > x0) && (x <= x_mid);
        hit.right = black && on_surface && in_rows && (x >= x_mid) && (x < x_end);
    end

endmodule

FILE: rtl/bitmap_side_collision_probe.sv
// Bitmap side collision probe: scans black surface pixels against four probe
// zones of a rectangle and reports the winning pixel of each zone per frame.
// Depends on bscp_pkg, bscp_pixel_if, bscp_result_if, bscp_zone and the assert header.
//
// Pixels arrive one per request on the pix channel in any order. A pixel
// whose red, green and blue are all zero is a hit; it is checked against the
// top, bottom, left and right halves of the configured rectangle, and each
// zone keeps its best hit (top: largest y then smallest x, bottom: smallest y
// then smallest x, left: largest x then smallest y, right: smallest x then
// smallest y). The block takes one pixel every clock cycle unless the input
// stalls (see below): a pixel is registered in the compare stage, then compared
// and folded into the kept hits as it leaves that stage. When the pixel marked
// last_pixel is folded in, the final hits are copied into a report buffer and
// the kept hits are cleared in the same cycle, so the next frame can stream in
// at once. The report leaves on the res channel: four requests (sides top,
// bottom, left, right, last set on the fourth) when report_mode is 0, or one
// request for the first found side when report_mode is 1 (side top with found
// low if no side holds a hit). Sides without a hit report zero coordinates.
// The first result is offered once the last pixel has left the compare stage
// and its hits are registered in the report buffer. Input stalls only when a
// second last pixel reaches the compare stage before the final result of the
// previous report is taken; a new report can load in the same cycle as that
// final result leaves. With a consumer that is always ready, frames with fewer
// pixels than a mode 0 report has requests see back pressure. Configuration goes
// through an APB-style port at byte addresses 0x00 (rect_left), 0x04
// (rect_top), 0x08 (rect_width), 0x0C (rect_height) and 0x10 (report_mode),
// and must only be written while no frame is in flight.
module bitmap_side_collision_probe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bscp_pkg::ADDR_W-1:0]   paddr,
    input  logic [bscp_pkg::DATA_W-1:0]   pwdata,
    output logic [bscp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    bscp_pixel_if.sink                    pix,
    bscp_result_if.source                 res
);

    localparam int NS = bscp_pkg::NUM_SIDES;
    localparam int CW = bscp_pkg::COORD_W;

    // Sides that rank on y first, and sides that prefer the larger primary
    // coordinate.
    localparam logic [NS-1:0] Y_MAJOR_SIDES =
        NS'((1 << bscp_pkg::SIDE_TOP) | (1 << bscp_pkg::SIDE_BOTTOM));
    localparam logic [NS-1:0] BIG_SIDES =
        NS'((1 << bscp_pkg::SIDE_TOP) | (1 << bscp_pkg::SIDE_LEFT));

    // Configuration registers.
    bscp_pkg::rect_cfg_t rect_reg;
    logic                mode_reg;
    logic                cfg_wr;
    logic [2:0]          reg_index;

    // Compare stage: one registered pixel.
    logic             stg_valid_reg;
    bscp_pkg::coord_t stg_x_reg, stg_y_reg;
    bscp_pkg::color_t stg_r_reg, stg_g_reg, stg_b_reg;
    logic             stg_last_reg;
    logic             stg_go;
    logic             pix_acc;
    logic             snap;

    // Kept hits of the current frame.
    logic [NS-1:0]    found_reg, found_next;
    bscp_pkg::coord_t best_x_reg [NS];
    bscp_pkg::coord_t best_x_next [NS];
    bscp_pkg::coord_t best_y_reg [NS];
    bscp_pkg::coord_t best_y_next [NS];
    bscp_pkg::zone_hit_t zone;
    logic [NS-1:0]    zone_vec;
    logic [NS-1:0]    upd_found;
    bscp_pkg::coord_t upd_x [NS];
    bscp_pkg::coord_t upd_y [NS];
    logic [1:0]       first_side;

    // Report buffer and output sequencing.
    logic             rpt_busy_reg;
    logic             rpt_mode_reg;
    logic [1:0]       rpt_first_reg;
    logic [1:0]       rpt_idx_reg;
    logic [NS-1:0]    rpt_found_reg;
    bscp_pkg::coord_t rpt_x_reg [NS];
    bscp_pkg::coord_t rpt_y_reg [NS];
    logic [1:0]       cur_side;
    logic             res_acc;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so there are no wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_index = paddr[bscp_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rect_reg <= '0;
            mode_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_index)
                bscp_pkg::REG_RECT_LEFT:   rect_reg.left <= pwdata[CW-1:0];
                bscp_pkg::REG_RECT_TOP:    rect_reg.top <= pwdata[CW-1:0];
                bscp_pkg::REG_RECT_WIDTH:  rect_reg.width <= pwdata[CW-1:0];
                bscp_pkg::REG_RECT_HEIGHT: rect_reg.height <= pwdata[CW-1:0];
                bscp_pkg::REG_REPORT_MODE: mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            bscp_pkg::REG_RECT_LEFT:   prdata = bscp_pkg::DATA_W'(rect_reg.left);
            bscp_pkg::REG_RECT_TOP:    prdata = bscp_pkg::DATA_W'(rect_reg.top);
            bscp_pkg::REG_RECT_WIDTH:  prdata = bscp_pkg::DATA_W'(rect_reg.width);
            bscp_pkg::REG_RECT_HEIGHT: prdata = bscp_pkg::DATA_W'(rect_reg.height);
            bscp_pkg::REG_REPORT_MODE: prdata = bscp_pkg::DATA_W'(mode_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register. A last pixel can only leave the compare stage once
    // the report buffer is free, or in the cycle where the final result of
    // the previous report is taken; everything else moves on every cycle.
    // ------------------------------------------------------------------
    assign res_acc = res.valid && res.ready;
    assign stg_go = stg_valid_reg
                    && (!stg_last_reg || !rpt_busy_reg || (res_acc && res.last));
    assign pix.ready = !stg_valid_reg || stg_go;
    assign pix_acc = pix.valid && pix.ready;
    assign snap = stg_go && stg_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
        end else if (pix_acc) begin
            stg_valid_reg <= 1'b1;
        end else if (stg_go) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc) begin
            stg_x_reg <= pix.pixel_x;
            stg_y_reg <= pix.pixel_y;
            stg_r_reg <= pix.red;
            stg_g_reg <= pix.green;
            stg_b_reg <= pix.blue;
            stg_last_reg <= pix.last_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Zone decode and best-hit update for the staged pixel.
    // ------------------------------------------------------------------
    bscp_zone u_zone (
        .rect  (rect_reg),
        .px    (stg_x_reg),
        .py    (stg_y_reg),
        .red   (stg_r_reg),
        .green (stg_g_reg),
        .blue  (stg_b_reg),
        .hit   (zone)
    );

    assign zone_vec = zone;

    always_comb
    begin
        for (int s = 0; s < NS; s++) begin
            // Top and bottom rank on y first; left and right rank on x first.
            // Top and left prefer the larger primary coordinate.
            if (stg_go && zone_vec[s] && bscp_pkg::side_better(
                    found_reg[s],
                    Y_MAJOR_SIDES[s] ? stg_y_reg : stg_x_reg,
                    Y_MAJOR_SIDES[s] ? stg_x_reg : stg_y_reg,
                    Y_MAJOR_SIDES[s] ? best_y_reg[s] : best_x_reg[s],
                    Y_MAJOR_SIDES[s] ? best_x_reg[s] : best_y_reg[s],
                    BIG_SIDES[s])) begin
                upd_found[s] = 1'b1;
                upd_x[s] = stg_x_reg;
                upd_y[s] = stg_y_reg;
            end else begin
                upd_found[s] = found_reg[s];
                upd_x[s] = best_x_reg[s];
                upd_y[s] = best_y_reg[s];
            end
        end

        // The last pixel of a frame hands its hits to the report buffer and
        // leaves a clean slate for the next frame.
        for (int s = 0; s < NS; s++) begin
            found_next[s] = snap ? 1'b0 : upd_found[s];
            best_x_next[s] = snap ? '0 : upd_x[s];
            best_y_next[s] = snap ? '0 : upd_y[s];
        end

        first_side = bscp_pkg::SIDE_TOP;
        for (int s = NS - 1; s >= 0; s--) begin
            if (upd_found[s]) begin
                first_side = 2'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            found_reg <= '0;
            for (int s = 0; s < NS; s++) begin
                best_x_reg[s] <= '0;
                best_y_reg[s] <= '0;
            end
        end else begin
            found_reg <= found_next;
            for (int s = 0; s < NS; s++) begin
                best_x_reg[s] <= best_x_next[s];
                best_y_reg[s] <= best_y_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Report buffer. Holds one frame's hits while the results drain, so the
    // next frame can already be scanned. A new report loaded in the cycle
    // where the final result leaves takes over the buffer at once.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rpt_busy_reg <= 1'b0;
            rpt_idx_reg <= '0;
        end else if (snap) begin
            rpt_busy_reg <= 1'b1;
            rpt_idx_reg <= '0;
        end else if (res_acc) begin
            if (res.last) begin
                rpt_busy_reg <= 1'b0;
            end
            rpt_idx_reg <= rpt_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap) begin
            rpt_mode_reg <= mode_reg;
            rpt_first_reg <= first_side;
            rpt_found_reg <= upd_found;
            for (int s = 0; s < NS; s++) begin
                rpt_x_reg[s] <= upd_x[s];
                rpt_y_reg[s] <= upd_y[s];
            end
        end
    end

    assign cur_side = rpt_mode_reg ? rpt_first_reg : rpt_idx_reg;

    assign res.valid = rpt_busy_reg;
    assign res.side = cur_side;
    assign res.found = rpt_found_reg[cur_side];
    assign res.hit_x = rpt_found_reg[cur_side] ? rpt_x_reg[cur_side] : '0;
    assign res.hit_y = rpt_found_reg[cur_side] ? rpt_y_reg[cur_side] : '0;
    assign res.last = rpt_mode_reg || (rpt_idx_reg == bscp_pkg::SIDE_RIGHT);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `include "bitmap_side_collision_probe_assert.svh"

    // Handing a frame to the report buffer must leave no kept hit behind.
    `BSCP_ASSERT_NEXT(a_snap_clears, snap, found_reg == '0)
    // Once the final result of a report is taken with no new report loading,
    // the channel goes quiet.
    `BSCP_ASSERT_NEXT(a_report_ends, res_acc && res.last && !snap, !res.valid)
    // A single-side report is a single request.
    `BSCP_ASSERT_SAME(a_mode1_single, res.valid && rpt_mode_reg, res.last)
    // A missing hit reports zero coordinates.
    `BSCP_ASSERT_SAME(a_empty_zero, res.valid && !res.found,
        (res.hit_x == '0) && (res.hit_y == '0))

endmodule

FILE: tb/bscp_tb_pkg.sv
`timescale 1ns / 100ps
// Report mode codes shared by the probe testbench files.
// Stands alone; the checker and the testbench top import it.
package bscp_tb_pkg;

    localparam logic MODE_ALL_SIDES = 1'b0;
    localparam logic MODE_FIRST_SIDE = 1'b1;

endpackage

FILE: tb/bscp_side_report_checker.sv
`timescale 1ns / 100ps
// Watches the pixel, result and register ports of the side collision probe, predicts
// each side report and compares it. Depends on bscp_pkg, bscp_tb_pkg and the
// channel interfaces.
module bscp_side_report_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [bscp_pkg::ADDR_W-1:0] paddr,
    input  logic [bscp_pkg::DATA_W-1:0] pwdata,
    bscp_pixel_if                       pix,
    bscp_result_if                      res,
    output int                          pending_reports,
    output int                          fail_count
);
    import bscp_pkg::*;
    import bscp_tb_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [1:0] side;
        logic       found;
        coord_t     hit_x;
        coord_t     hit_y;
        logic       last;
    } side_report_t;

    // Shadow of the configuration registers.
    coord_t cfg_left;
    coord_t cfg_top;
    coord_t cfg_width;
    coord_t cfg_height;
    logic   cfg_mode;

    // Best hit kept per side for the frame in progress.
    logic   held[NUM_SIDES];
    coord_t held_x[NUM_SIDES];
    coord_t held_y[NUM_SIDES];

    side_report_t side_reports_due[$];
    int           mismatches;

    function automatic void clear_hits();
        for (int s = 0; s < NUM_SIDES; s++) begin
            held[s] = 1'b0;
            held_x[s] = '0;
            held_y[s] = '0;
        end
    endfunction

    // The primary coordinate is y when y_major is set; prefer_big picks the larger
    // primary value, and a tie goes to the smaller secondary value.
    function automatic void keep_if_better(input int s, input coord_t x, input coord_t y,
                                           input logic y_major, input logic prefer_big);
        coord_t cand_p;
        coord_t cand_s;
        coord_t kept_p;
        coord_t kept_s;
        logic   take;
        cand_p = y_major ? y : x;
        cand_s = y_major ? x : y;
        kept_p = y_major ? held_y[s] : held_x[s];
        kept_s = y_major ? held_x[s] : held_y[s];
        if (!held[s]) begin
            take = 1'b1;
        end
        else if (cand_p != kept_p) begin
            take = prefer_big ? (cand_p > kept_p) : (cand_p < kept_p);
        end
        else begin
            take = cand_s < kept_s;
        end
        if (take) begin
            held[s] = 1'b1;
            held_x[s] = x;
            held_y[s] = y;
        end
    endfunction

    function automatic side_report_t summarize_side(input int s, input logic is_last);
        side_report_t rep;
        rep.side = s[1:0];
        rep.found = held[s];
        rep.hit_x = held[s] ? held_x[s] : '0;
        rep.hit_y = held[s] ? held_y[s] : '0;
        rep.last = is_last;
        return rep;
    endfunction

    function automatic void fold_pixel(input coord_t x, input coord_t y, input color_t r,
                                       input color_t g, input color_t b, input logic lp);
        int   x0;
        int   y0;
        int   w;
        int   h;
        int   xi;
        int   yi;
        int   xmid;
        int   ymid;
        int   first;
        logic in_cols;
        logic in_rows;
        x0 = int'(cfg_left);
        y0 = int'(cfg_top);
        w = int'(cfg_width);
        h = int'(cfg_height);
        xi = int'(x);
        yi = int'(y);
        xmid = x0 + w / 2;
        ymid = y0 + h / 2;
        in_cols = xi >= x0 && xi < x0 + w - 1;
        in_rows = yi >= y0 && yi < y0 + h - 1;
        if (r == BLACK_LEVEL && g == BLACK_LEVEL && b == BLACK_LEVEL &&
            xi < int'(SURFACE_DIM) && yi < int'(SURFACE_DIM)) begin
            if (in_cols && yi > y0 && yi <= ymid)
                keep_if_better(int'(SIDE_TOP), x, y, 1'b1, 1'b1);
            if (in_cols && yi >= ymid && yi < y0 + h)
                keep_if_better(int'(SIDE_BOTTOM), x, y, 1'b1, 1'b0);
            if (in_rows && xi > x0 && xi <= xmid)
                keep_if_better(int'(SIDE_LEFT), x, y, 1'b0, 1'b1);
            if (in_rows && xi >= xmid && xi < x0 + w)
                keep_if_better(int'(SIDE_RIGHT), x, y, 1'b0, 1'b0);
        end
        if (lp) begin
            if (cfg_mode == MODE_ALL_SIDES) begin
                for (int s = 0; s < NUM_SIDES; s++)
                    side_reports_due = {side_reports_due,
                                        summarize_side(s, s == NUM_SIDES - 1)};
            end
            else begin
                // Only the first side that holds a hit; top with no hit when none does.
                first = int'(SIDE_TOP);
                for (int s = NUM_SIDES - 1; s >= 0; s--)
                    if (held[s])
                        first = s;
                side_reports_due = {side_reports_due, summarize_side(first, 1'b1)};
            end
            clear_hits();
        end
    endfunction

    function automatic void write_register(input logic [2:0] idx,
                                           input logic [DATA_W-1:0] data);
        case (idx)
            REG_RECT_LEFT:   cfg_left = data[COORD_W-1:0];
            REG_RECT_TOP:    cfg_top = data[COORD_W-1:0];
            REG_RECT_WIDTH:  cfg_width = data[COORD_W-1:0];
            REG_RECT_HEIGHT: cfg_height = data[COORD_W-1:0];
            REG_REPORT_MODE: cfg_mode = data[0];
            default: ;
        endcase
    endfunction

    function automatic void check_report();
        side_report_t want;
        if (side_reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("unexpected result: side %0d found %0b x %0d y %0d last %0b",
                         res.side, res.found, res.hit_x, res.hit_y, res.last);
            return;
        end
        want = side_reports_due.pop_front();
        if (res.side !== want.side || res.found !== want.found || res.hit_x !== want.hit_x ||
            res.hit_y !== want.hit_y || res.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display({"result mismatch: expected side %0d found %0b x %0d y %0d ",
                          "last %0b, got side %0d found %0b x %0d y %0d last %0b"},
                         want.side, want.found, want.hit_x, want.hit_y, want.last,
                         res.side, res.found, res.hit_x, res.hit_y, res.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_left = '0;
            cfg_top = '0;
            cfg_width = '0;
            cfg_height = '0;
            cfg_mode = MODE_ALL_SIDES;
            clear_hits();
            side_reports_due.delete();
            mismatches = 0;
            pending_reports <= 0;
            fail_count <= 0;
        end
        else begin
            if (res.valid && res.ready)
                check_report();
            if (psel && penable && pwrite && pready)
                write_register(paddr[ADDR_W-1:2], pwdata);
            if (pix.valid && pix.ready)
                fold_pixel(pix.pixel_x, pix.pixel_y, pix.red, pix.green, pix.blue,
                           pix.last_pixel);
            pending_reports <= side_reports_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: tb/tb_bitmap_side_collision_probe.sv
`timescale 1ns / 100ps
// Testbench top of the side collision probe: clock, reset, register writes, pixel
// stimulus, result back pressure and verdict. Depends on bscp_pkg, bscp_tb_pkg,
// the channel interfaces, bscp_side_report_checker and the probe itself.
module tb_bitmap_side_collision_probe;
    import bscp_pkg::*;
    import bscp_tb_pkg::*;

    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int GAP_PERCENT = 34;
    // Long enough for the report buffer to fill and the pixel input to stall.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles without any accepted request before the run is declared hung. The
    // longest legal quiet spell is the hold-off above; register writes count as activity.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_PIXELS = 40;
    localparam int RANDOM_PHASES = 8;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shared knobs between the stimulus and the result sink. no_idle switches off
    // random gaps on both sides; hold_off_go asks the sink for one long stall.
    bit                  no_idle;
    bit                  hold_off_go;

    int                  pending_reports;
    int                  fail_count;
    int                  idle_cycles;

    bscp_pixel_if  pix_ch ();
    bscp_result_if res_ch ();

    bitmap_side_collision_probe i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_ch),
        .res     (res_ch)
    );

    bscp_side_report_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pix             (pix_ch),
        .res             (res_ch),
        .pending_reports (pending_reports),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // One register write: a setup phase, then the access phase, which completes
    // at the edge where pready is seen high. psel is left up so that writes can
    // follow back to back; the caller lowers it once at the end.
    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Writes every register. Only called while the block is idle.
    task automatic configure(input coord_t left, input coord_t top, input coord_t width,
                             input coord_t height, input logic mode);
        reg_write(REG_RECT_LEFT, DATA_W'(left));
        reg_write(REG_RECT_TOP, DATA_W'(top));
        reg_write(REG_RECT_WIDTH, DATA_W'(width));
        reg_write(REG_RECT_HEIGHT, DATA_W'(height));
        reg_write(REG_REPORT_MODE, DATA_W'(mode));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one pixel request, after a random number of idle cycles unless gaps
    // are switched off, and returns at the edge where it is accepted. valid stays
    // high so that the next request can follow without a bubble.
    task automatic send_pixel(input coord_t x, input coord_t y, input color_t r,
                              input color_t g, input color_t b, input logic lp);
        while (!no_idle && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_x <= x;
        pix_ch.pixel_y <= y;
        pix_ch.red <= r;
        pix_ch.green <= g;
        pix_ch.blue <= b;
        pix_ch.last_pixel <= lp;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering pixels and waits until every predicted report has arrived,
    // then waits out the given tail so that any pixel still in the pipeline settles.
    task automatic drain_reports(input int tail_cycles);
        pix_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports != 0);
        repeat (tail_cycles) @(posedge clk);
    endtask

    // A coordinate a little around the span [base, base+span], clipped to the surface.
    function automatic coord_t coord_around(input int base, input int span);
        int v;
        v = base - 2 + int'($urandom_range(0, span + 4));
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    // Rectangle corner: mostly anywhere, sometimes at either edge of the surface.
    function automatic coord_t pick_corner();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return coord_t'(COORD_MAX);
            default: return coord_t'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // Rectangle extent: mostly small so that hits collide and ties happen,
    // sometimes empty or thin, sometimes the full surface.
    function automatic coord_t pick_extent();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 3));
            1: return coord_t'(COORD_MAX);
            default: return coord_t'($urandom_range(4, 48));
        endcase
    endfunction

    // One random setting followed by frames of one to ten pixels. Most pixels are
    // black and near the rectangle, so the zones really compete; the rest are
    // colored, nearly black, or anywhere on the surface. The phase always ends
    // on a pixel marked last, so no hits are carried into the next setting.
    task automatic random_phase(input int n_pixels);
        coord_t l;
        coord_t t;
        coord_t w;
        coord_t h;
        coord_t x;
        coord_t y;
        color_t r;
        color_t g;
        color_t b;
        logic   lp;
        int     frame_left;
        int     pick;
        l = pick_corner();
        t = pick_corner();
        w = pick_extent();
        h = pick_extent();
        configure(l, t, w, h, 1'($urandom_range(0, 1)));
        frame_left = $urandom_range(1, 10);
        for (int i = 0; i < n_pixels; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                x = coord_around(int'(l), int'(w));
                y = coord_around(int'(t), int'(h));
            end
            else
            begin
                x = coord_t'($urandom_range(0, COORD_MAX));
                y = coord_t'($urandom_range(0, COORD_MAX));
            end
            r = '0;
            g = '0;
            b = '0;
            pick = $urandom_range(0, 99);
            if (pick >= 85)
                {r, g, b} = 24'($urandom);
            else if (pick >= 65)
            begin
                // Nearly black: a single component is off zero.
                case ($urandom_range(0, 2))
                    0: r = color_t'($urandom_range(1, 255));
                    1: g = color_t'($urandom_range(1, 255));
                    default: b = color_t'($urandom_range(1, 255));
                endcase
            end
            frame_left--;
            lp = (frame_left == 0) || (i == n_pixels - 1);
            if (frame_left == 0)
                frame_left = $urandom_range(1, 10);
            send_pixel(x, y, r, g, b, lp);
        end
        drain_reports(8);
    endtask

    // Result sink: ready at random, always ready while gaps are off, and one long
    // stall on request, counted here while the stimulus keeps offering pixels.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    // Watchdog: ends the run when no request has moved on any port for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (pix_ch.valid && pix_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        no_idle = 1'b0;
        hold_off_go = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_x <= '0;
        pix_ch.pixel_y <= '0;
        pix_ch.red <= '0;
        pix_ch.green <= '0;
        pix_ch.blue <= '0;
        pix_ch.last_pixel <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames on a 20 by 10 rectangle at (100, 200). The top zone
        // covers rows 201..205, the bottom zone rows 205..209, both over columns
        // 100..118; the left zone covers columns 101..110, the right zone columns
        // 110..119, both over rows 200..208.
        configure(12'd100, 12'd200, 12'd20, 12'd10, MODE_ALL_SIDES);
        send_pixel(12'd105, 12'd203, 8'h00, 8'h00, 8'h00, 1'b0);    // top and left
        send_pixel(12'd112, 12'd203, 8'h00, 8'h00, 8'h00, 1'b0);    // top and right
        send_pixel(12'd112, 12'd205, 8'h00, 8'h00, 8'h00, 1'b0);    // on the middle row
        send_pixel(12'd101, 12'd201, 8'h01, 8'h00, 8'h00, 1'b0);    // red is not a hit
        send_pixel(12'd101, 12'd201, 8'h00, 8'h80, 8'h00, 1'b0);
        send_pixel(12'd101, 12'd201, 8'h00, 8'h00, 8'hff, 1'b0);
        send_pixel(12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 1'b0);    // far corner
        send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b0);        // origin
        send_pixel(12'd112, 12'd203, 8'h00, 8'h00, 8'h00, 1'b0);    // repeated pixel
        send_pixel(12'd100, 12'd201, 8'h00, 8'h00, 8'h00, 1'b0);    // left edge column
        // The report is triggered by a white pixel off the rectangle.
        send_pixel(12'hfff, 12'd0, 8'hff, 8'hff, 8'hff, 1'b1);
        // A frame of one pixel with no hit: all four sides report nothing.
        send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // First found side only: bottom here, then nothing at all.
        configure(12'd100, 12'd200, 12'd20, 12'd10, MODE_FIRST_SIDE);
        send_pixel(12'd115, 12'd207, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(12'hfff, 12'hfff, 8'h00, 8'h00, 8'h01, 1'b1);
        send_pixel(12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // Largest register values: the zones run past the surface edge.
        configure(12'hfff, 12'hfff, 12'hfff, 12'hfff, MODE_FIRST_SIDE);
        send_pixel(12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // Whole-surface rectangle: the midpoint lands in all four zones.
        configure(12'd0, 12'd0, 12'hfff, 12'hfff, MODE_ALL_SIDES);
        send_pixel(12'd2047, 12'd2047, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(12'd4093, 12'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(12'd1, 12'd1, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // Empty zones: width and height zero.
        configure(12'd0, 12'd0, 12'd0, 12'd0, MODE_ALL_SIDES);
        send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // Thin zones of a 2 by 2 rectangle: each holds a single pixel.
        configure(12'd0, 12'd0, 12'd2, 12'd2, MODE_ALL_SIDES);
        send_pixel(12'd0, 12'd1, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(12'd1, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        drain_reports(8);

        // Random settings and frames. One phase runs with no gaps on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idle = (p == 3);
            random_phase(PHASE_PIXELS);
        end
        no_idle = 1'b0;

        // Back pressure: the sink stalls for a long stretch while short frames
        // keep coming, so the report buffer fills and the pixel input stalls.
        configure(12'd40, 12'd40, 12'd16, 12'd16, MODE_ALL_SIDES);
        hold_off_go = 1'b1;
        for (int i = 0; i < 30; i++)
            send_pixel(coord_around(40, 16), coord_around(40, 16), 8'h00, 8'h00, 8'h00,
                       1'(i % 2));
        drain_reports(12);

        if (fail_count == 0 && pending_reports == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
